FILE: src/hdq_pkg.sv
package hdq_pkg;

  typedef enum logic [1:0] {
    LVL_LOW  = 2'd0,
    LVL_HIGH = 2'd1,
    LVL_UNK  = 2'd2
  } level_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_HIGH = 2'd1,
    EV_LOW  = 2'd2
  } event_t;

  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_THRESHOLD  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_THRESHOLD   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_RUN_TARGET = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_RUN_TARGET  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_DELAY      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_DELAY       = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INITIAL_STATE   = 3'd6;

  localparam int RUN_TARGET_BITS = 8;
  localparam int RUN_BITS        = 9;
  localparam logic [RUN_BITS-1:0] RUN_MAX = 9'd256;

  localparam int OUT_DATA_BITS = 8;

  // code 3 reads as unknown
  function automatic level_t level_code(input logic [1:0] code);
    level_t lvl;
    case (code)
      2'd0:    lvl = LVL_LOW;
      2'd1:    lvl = LVL_HIGH;
      default: lvl = LVL_UNK;
    endcase
    return lvl;
  endfunction

endpackage

FILE: src/hysteresis_debounce_qualifier_core.sv
// Hysteresis comparator with debounce qualifier.
// Slave stream s_*: s_tuser is the item kind (0 sample, 1 tick), s_tdata holds
// the sample in its low SAMPLE_BITS bits as two's complement. Master stream m_*:
// one result per request, m_tdata carries confirmed level, candidate level and
// event code. Configuration channel cfg_*: cfg_index selects a register, writes
// are taken in any cycle (cfg_ready is tied high) and must only be issued while
// no request is in flight; writing the initial state also loads both levels.
// An accepted request passes an input register, then one pass of compare and
// count logic into the result register. Throughput is one request per cycle
// while m_tready takes each result, set by that single pass; the level, run,
// pending and timer registers are all updated in the same cycle.
// Reset clears both streams, loads default register values and sets confirmed
// and candidate levels to low with no delay pending. When m_tready is low the
// result holds, the input register still fills once, and s_tready then drops
// until the result is taken.
module hysteresis_debounce_qualifier_core #(
  parameter int SAMPLE_BITS = 16,
  parameter int DELAY_BITS  = 16,
  localparam int InBits  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int WideBits = (SAMPLE_BITS > DELAY_BITS) ? SAMPLE_BITS : DELAY_BITS,
  localparam int CfgBits = (WideBits > 8) ? WideBits : 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [InBits-1:0]                    s_tdata,   // sample
  input  logic                                 s_tuser,   // kind
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [hdq_pkg::OUT_DATA_BITS-1:0]    m_tdata,   // confirmed_state, candidate_state, event_res
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hdq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [CfgBits-1:0]                   cfg_data
);
  import hdq_pkg::*;

  logic signed [SAMPLE_BITS-1:0]  high_threshold;
  logic signed [SAMPLE_BITS-1:0]  low_threshold;
  logic [RUN_TARGET_BITS-1:0]     high_run_target;
  logic [RUN_TARGET_BITS-1:0]     low_run_target;
  logic [DELAY_BITS-1:0]          high_delay;
  logic [DELAY_BITS-1:0]          low_delay;

  logic                           s1_valid;
  logic                           s1_kind;
  logic signed [SAMPLE_BITS-1:0]  s1_sample;

  logic signed [SAMPLE_BITS-1:0]  previous_sample;
  level_t                         confirmed;
  level_t                         candidate;
  logic [RUN_BITS-1:0]            high_run;
  logic [RUN_BITS-1:0]            low_run;
  logic                           pending_high;
  logic                           pending_low;
  logic [DELAY_BITS-1:0]          delay_left;

  level_t                         confirmed_next;
  level_t                         candidate_next;
  logic [RUN_BITS-1:0]            high_run_next;
  logic [RUN_BITS-1:0]            low_run_next;
  logic                           pending_high_next;
  logic                           pending_low_next;
  logic [DELAY_BITS-1:0]          delay_left_next;
  event_t                         event_next;

  logic advance;
  logic process;
  logic below_high;
  logic prev_below_high;
  logic below_low;
  logic prev_below_low;
  logic above_low;
  logic [DELAY_BITS-1:0] delay_dec;

  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = !s1_valid || advance;
  assign process   = s1_valid && advance;
  assign cfg_ready = 1'b1;

  assign below_high      = s1_sample < high_threshold;
  assign prev_below_high = previous_sample < high_threshold;
  assign below_low       = s1_sample < low_threshold;
  assign prev_below_low  = previous_sample < low_threshold;
  assign above_low       = s1_sample > low_threshold;
  assign delay_dec       = (delay_left != '0) ? delay_left - 1'b1 : delay_left;

  always_comb begin
    confirmed_next    = confirmed;
    candidate_next    = candidate;
    high_run_next     = high_run;
    low_run_next      = low_run;
    pending_high_next = pending_high;
    pending_low_next  = pending_low;
    delay_left_next   = delay_left;
    event_next        = EV_NONE;

    if (s1_kind) begin
      if (pending_high || pending_low) begin
        delay_left_next = delay_dec;
        if (delay_dec == '0) begin
          if (pending_high) begin
            confirmed_next = LVL_HIGH;
            event_next     = EV_HIGH;
          end else begin
            confirmed_next = LVL_LOW;
            event_next     = EV_LOW;
          end
          pending_high_next = 1'b0;
          pending_low_next  = 1'b0;
        end
      end
    end else if (!(below_high && confirmed != LVL_HIGH && candidate != LVL_HIGH)) begin
      if (prev_below_high && !below_high && confirmed != LVL_HIGH) begin
        candidate_next = LVL_HIGH;
      end else if (!prev_below_low && below_low && confirmed != LVL_LOW) begin
        candidate_next = LVL_LOW;
      end else if (candidate == LVL_HIGH && below_high) begin
        candidate_next = LVL_UNK;
      end else if (candidate == LVL_LOW && above_low) begin
        candidate_next = LVL_UNK;
      end

      if (candidate_next == LVL_HIGH) begin
        high_run_next    = (high_run < RUN_MAX) ? high_run + 1'b1 : high_run;
        low_run_next     = '0;
        pending_low_next = 1'b0;
        if (high_run_next == {1'b0, high_run_target} && confirmed != LVL_HIGH) begin
          pending_high_next = 1'b1;
          delay_left_next   = high_delay;
          if (high_delay == '0) begin
            confirmed_next    = LVL_HIGH;
            event_next        = EV_HIGH;
            pending_high_next = 1'b0;
          end
        end
      end else if (candidate_next == LVL_LOW) begin
        low_run_next      = (low_run < RUN_MAX) ? low_run + 1'b1 : low_run;
        high_run_next     = '0;
        pending_high_next = 1'b0;
        if (low_run_next == {1'b0, low_run_target} && confirmed != LVL_LOW) begin
          pending_low_next = 1'b1;
          delay_left_next  = low_delay;
          if (low_delay == '0) begin
            confirmed_next   = LVL_LOW;
            event_next       = EV_LOW;
            pending_low_next = 1'b0;
          end
        end
      end else begin
        high_run_next     = '0;
        low_run_next      = '0;
        pending_high_next = 1'b0;
        pending_low_next  = 1'b0;
      end
      if (!pending_high_next && !pending_low_next) begin
        delay_left_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      s1_kind   <= s_tuser;
      s1_sample <= s_tdata[SAMPLE_BITS-1:0];
    end
    if (process) begin
      m_tdata <= {{(OUT_DATA_BITS - 6){1'b0}}, event_next, candidate_next, confirmed_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      m_tvalid        <= 1'b0;
      high_threshold  <= SAMPLE_BITS'(1);
      low_threshold   <= '0;
      high_run_target <= RUN_TARGET_BITS'(1);
      low_run_target  <= RUN_TARGET_BITS'(1);
      high_delay      <= DELAY_BITS'(1000);
      low_delay       <= DELAY_BITS'(1000);
      previous_sample <= '0;
      confirmed       <= LVL_LOW;
      candidate       <= LVL_LOW;
      high_run        <= '0;
      low_run         <= '0;
      pending_high    <= 1'b0;
      pending_low     <= 1'b0;
      delay_left      <= '0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= s1_valid;
      end
      if (process) begin
        if (!s1_kind) begin
          previous_sample <= s1_sample;
        end
        confirmed    <= confirmed_next;
        candidate    <= candidate_next;
        high_run     <= high_run_next;
        low_run      <= low_run_next;
        pending_high <= pending_high_next;
        pending_low  <= pending_low_next;
        delay_left   <= delay_left_next;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_HIGH_THRESHOLD:  high_threshold  <= cfg_data[SAMPLE_BITS-1:0];
          REG_LOW_THRESHOLD:   low_threshold   <= cfg_data[SAMPLE_BITS-1:0];
          REG_HIGH_RUN_TARGET: high_run_target <= cfg_data[RUN_TARGET_BITS-1:0];
          REG_LOW_RUN_TARGET:  low_run_target  <= cfg_data[RUN_TARGET_BITS-1:0];
          REG_HIGH_DELAY:      high_delay      <= cfg_data[DELAY_BITS-1:0];
          REG_LOW_DELAY:       low_delay       <= cfg_data[DELAY_BITS-1:0];
          REG_INITIAL_STATE: begin
            confirmed <= level_code(cfg_data[1:0]);
            candidate <= level_code(cfg_data[1:0]);
          end
          default: ;
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_single_pending: assert property (@(posedge clk) disable iff (rst)
    !(pending_high && pending_low))
    else $error("high and low confirmations pending together");

  a_idle_timer_clear: assert property (@(posedge clk) disable iff (rst)
    (!pending_high && !pending_low) |-> (delay_left == '0))
    else $error("delay timer running with nothing pending");

  a_high_event_level: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[5:4] == EV_HIGH) |-> (m_tdata[1:0] == LVL_HIGH))
    else $error("high event without high confirmed level");

  a_low_event_level: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[5:4] == EV_LOW) |-> (m_tdata[1:0] == LVL_LOW))
    else $error("low event without low confirmed level");

  a_run_exclusive: assert property (@(posedge clk) disable iff (rst)
    process |=> !(high_run != '0 && low_run != '0))
    else $error("high and low runs counting together");
`endif

endmodule
